FILE: rtl/ppt_pkg.sv
// Shared types, widths and codes for the playback position transport.
// Used by ppt_urem and playback_position_transport_top; no dependencies.
`timescale 1ns / 1ps

package ppt_pkg;

   localparam int POS_FRAC_BITS   = 16;
   localparam int SPEED_FRAC_BITS = 8;
   localparam int DELTA_FRAC_BITS = 16;

   localparam int POS_W    = 32;
   localparam int DELTA_W  = 16;
   localparam int SPEED_W  = 12;
   localparam int FRAME_W  = 17;
   localparam int MODE_W   = 2;
   localparam int OP_W     = 4;
   localparam int STATE_W  = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam int SPEED_MIN_Q = ((1 << SPEED_FRAC_BITS) + 99) / 100;
   localparam int SPEED_MAX_Q = 10 << SPEED_FRAC_BITS;

   localparam logic [SPEED_W-1:0] SPEED_RESET = 12'd256;
   localparam logic [FRAME_W-1:0] FRAME_RESET = 17'd2185;

   localparam int PROD_W = DELTA_W + SPEED_W;
   localparam int SHIFT  = DELTA_FRAC_BITS + SPEED_FRAC_BITS - POS_FRAC_BITS;
   localparam int SH_R   = (SHIFT > 0) ? SHIFT : 0;
   localparam int SH_L   = (SHIFT < 0) ? -SHIFT : 0;
   localparam int STEP_W = PROD_W - SH_R + SH_L;
   localparam int DVD_W  = ((STEP_W > POS_W) ? STEP_W : POS_W) + 1;
   localparam int NP_W   = DVD_W + 2;
   localparam int CNT_W  = $clog2(DVD_W + 1);

   typedef enum logic [OP_W-1:0] {
      OP_TICK        = 4'd0,
      OP_PLAY        = 4'd1,
      OP_PAUSE       = 4'd2,
      OP_RESUME      = 4'd3,
      OP_STOP        = 4'd4,
      OP_SEEK        = 4'd5,
      OP_STEP_FWD    = 4'd6,
      OP_STEP_BACK   = 4'd7,
      OP_SCRUB_BEGIN = 4'd8,
      OP_SCRUB_TO    = 4'd9,
      OP_SCRUB_END   = 4'd10
   } op_type;

   typedef enum logic [STATE_W-1:0] {
      RUN_STOPPED = 2'd0,
      RUN_PLAYING = 2'd1,
      RUN_PAUSED  = 2'd2,
      RUN_SCRUB   = 2'd3
   } run_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_NONE  = 2'd0,
      MODE_WHOLE = 2'd1,
      MODE_RANGE = 2'd2,
      MODE_PING  = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DURATION     = 3'd0,
      CSR_LOOP_START   = 3'd1,
      CSR_LOOP_END     = 3'd2,
      CSR_LOOP_MODE    = 3'd3,
      CSR_SPEED        = 3'd4,
      CSR_FRAME_PERIOD = 3'd5
   } csr_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_DECODE,
      SEQ_STEP,
      SEQ_EDGE,
      SEQ_DIV,
      SEQ_WRAP,
      SEQ_SEND
   } seq_type;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [POS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic [POS_W-1:0] remainder;
   } div_rsp_type;

endpackage

FILE: rtl/ppt_urem.sv
// Restoring unsigned remainder unit, one quotient bit per cycle.
// Depends on ppt_pkg for widths and the request/status structs.
`timescale 1ns / 1ps

module ppt_urem (
   input  logic                 clock,
   input  logic                 reset,
   input  ppt_pkg::div_req_type div_req,
   output ppt_pkg::div_rsp_type div_rsp
);

   logic                        busy_ff, busy_in;
   logic [ppt_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [ppt_pkg::DVD_W-1:0]   dvd_ff, dvd_in;
   logic [ppt_pkg::POS_W-1:0]   dsr_ff, dsr_in;
   logic [ppt_pkg::POS_W-1:0]   rem_ff, rem_in;
   logic [ppt_pkg::POS_W:0]     trial;
   logic [ppt_pkg::POS_W:0]     diff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, dvd_ff[ppt_pkg::DVD_W-1]};
      diff    = trial - {1'b0, dsr_ff};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = ppt_pkg::CNT_W'(ppt_pkg::DVD_W);
         dvd_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[ppt_pkg::DVD_W-2:0], 1'b0};
         rem_in = (trial >= {1'b0, dsr_ff}) ? diff[ppt_pkg::POS_W-1:0]
                                            : trial[ppt_pkg::POS_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == ppt_pkg::CNT_W'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign div_rsp.busy      = busy_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

FILE: rtl/playback_position_transport_top.sv
// Playback position transport: sequencer, position state and result register.
// Depends on ppt_pkg and on ppt_urem for the loop-length remainder.
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  operation, delta_time, target_time
// rsp       out        rsp_valid/rsp_ready  position, play_state, reverse,
//                                           loops_done, loop_completed, reached_end
// csr       in         csr_wr_en            csr_index, csr_data
//
// Each request passes through the decode and send states; a playing tick also passes
// through the step and edge states, and a tick that wraps a loop of nonzero length
// in whole or range mode also waits in the divide state on the remainder unit before
// the wrap state. req_ready is high only while the sequencer is idle; a finished
// result waits in the output register, and the sequencer holds before loading the
// next one until that result is taken. Reset is synchronous and needs no clearing pass.

module playback_position_transport_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [ppt_pkg::OP_W-1:0]        req_operation,
   input  logic [ppt_pkg::DELTA_W-1:0]     req_delta_time,
   input  logic [ppt_pkg::POS_W-1:0]       req_target_time,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ppt_pkg::POS_W-1:0]       rsp_position,
   output logic [ppt_pkg::STATE_W-1:0]     rsp_play_state,
   output logic                            rsp_reverse,
   output logic [ppt_pkg::POS_W-1:0]       rsp_loops_done,
   output logic                            rsp_loop_completed,
   output logic                            rsp_reached_end,
   input  logic                            csr_wr_en,
   input  logic [ppt_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ppt_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int PW = ppt_pkg::POS_W;
   localparam int NW = ppt_pkg::NP_W;

   function automatic logic [PW-1:0] clamp_dur(input logic signed [PW+1:0] t,
                                               input logic [PW-1:0] dur);
      logic [PW-1:0] r;
      if (t < 0) r = '0;
      else if (t > $signed({2'b00, dur})) r = dur;
      else r = t[PW-1:0];
      return r;
   endfunction

   function automatic logic [PW-1:0] sat_pos(input logic signed [NW-1:0] t);
      logic [PW-1:0] r;
      if (t < 0) r = '0;
      else if (t > $signed(NW'({PW{1'b1}}))) r = {PW{1'b1}};
      else r = t[PW-1:0];
      return r;
   endfunction

   // configuration
   logic [PW-1:0]                    duration_ff, loop_start_ff, loop_end_ff;
   logic [ppt_pkg::MODE_W-1:0]       loop_mode_ff;
   logic [ppt_pkg::SPEED_W-1:0]      speed_ff;
   logic [ppt_pkg::FRAME_W-1:0]      frame_period_ff;

   // sequencer and transport state
   ppt_pkg::seq_type                 seq_ff, seq_in;
   logic [PW-1:0]                    cur_ff, cur_in;
   logic [ppt_pkg::STATE_W-1:0]      run_ff, run_in;
   logic [ppt_pkg::STATE_W-1:0]      saved_ff, saved_in;
   logic                             bwd_ff, bwd_in;
   logic [PW-1:0]                    cnt_ff, cnt_in;
   logic                             wrapped_ff, wrapped_in;
   logic                             ended_ff, ended_in;

   // request and working registers
   logic [ppt_pkg::OP_W-1:0]         op_ff, op_in;
   logic [ppt_pkg::DELTA_W-1:0]      delta_ff, delta_in;
   logic [PW-1:0]                    target_ff, target_in;
   logic [ppt_pkg::PROD_W-1:0]       prod_ff, prod_in;
   logic [PW-1:0]                    lo_ff, lo_in, hi_ff, hi_in, len_ff, len_in;
   logic signed [NW-1:0]             np_ff, np_in;

   // result register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0]                    rsp_position_ff, rsp_position_in;
   logic [ppt_pkg::STATE_W-1:0]      rsp_state_ff, rsp_state_in;
   logic                             rsp_reverse_ff, rsp_reverse_in;
   logic [PW-1:0]                    rsp_loops_ff, rsp_loops_in;
   logic                             rsp_wrap_ff, rsp_wrap_in;
   logic                             rsp_end_ff, rsp_end_in;

   ppt_pkg::div_req_type             div_req;
   ppt_pkg::div_rsp_type             div_rsp;

   logic [ppt_pkg::SPEED_W-1:0]      spd;
   logic [PW-1:0]                    pair_lo, pair_hi;
   logic [ppt_pkg::PROD_W+ppt_pkg::SH_L-1:0] prod_wide;
   logic [ppt_pkg::STEP_W-1:0]       step;
   logic signed [NW-1:0]             hi_s, lo_s, refl;
   logic                             hit;

   ppt_urem u_urem (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      seq_in       = seq_ff;
      cur_in       = cur_ff;
      run_in       = run_ff;
      saved_in     = saved_ff;
      bwd_in       = bwd_ff;
      cnt_in       = cnt_ff;
      wrapped_in   = wrapped_ff;
      ended_in     = ended_ff;
      op_in        = op_ff;
      delta_in     = delta_ff;
      target_in    = target_ff;
      prod_in      = prod_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      len_in       = len_ff;
      np_in        = np_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_position_in = rsp_position_ff;
      rsp_state_in    = rsp_state_ff;
      rsp_reverse_in  = rsp_reverse_ff;
      rsp_loops_in    = rsp_loops_ff;
      rsp_wrap_in     = rsp_wrap_ff;
      rsp_end_in      = rsp_end_ff;
      req_ready    = (seq_ff == ppt_pkg::SEQ_IDLE);
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = len_ff;

      if (32'(speed_ff) < 32'(ppt_pkg::SPEED_MIN_Q))
         spd = ppt_pkg::SPEED_W'(ppt_pkg::SPEED_MIN_Q);
      else if (32'(speed_ff) > 32'(ppt_pkg::SPEED_MAX_Q))
         spd = ppt_pkg::SPEED_W'(ppt_pkg::SPEED_MAX_Q);
      else
         spd = speed_ff;

      pair_lo = (loop_start_ff < loop_end_ff) ? loop_start_ff : loop_end_ff;
      pair_hi = (loop_start_ff < loop_end_ff) ? loop_end_ff : loop_start_ff;
      if (pair_lo > duration_ff) pair_lo = duration_ff;
      if (pair_hi > duration_ff) pair_hi = duration_ff;

      prod_wide = (ppt_pkg::PROD_W + ppt_pkg::SH_L)'(prod_ff) << ppt_pkg::SH_L;
      step      = ppt_pkg::STEP_W'(prod_wide >> ppt_pkg::SH_R);

      hi_s = $signed(NW'(hi_ff));
      lo_s = $signed(NW'(lo_ff));
      hit  = bwd_ff ? (np_ff <= lo_s) : (np_ff >= hi_s);
      refl = bwd_ff ? ($signed(NW'({lo_ff, 1'b0})) - np_ff)
                    : ($signed(NW'({hi_ff, 1'b0})) - np_ff);

      unique case (seq_ff)
         ppt_pkg::SEQ_IDLE: begin
            if (req_valid) begin
               op_in     = req_operation;
               delta_in  = req_delta_time;
               target_in = req_target_time;
               seq_in    = ppt_pkg::SEQ_DECODE;
            end
         end
         ppt_pkg::SEQ_DECODE: begin
            wrapped_in = 1'b0;
            ended_in   = 1'b0;
            seq_in     = ppt_pkg::SEQ_SEND;
            case (op_ff)
               ppt_pkg::OP_TICK: begin
                  if (run_ff == ppt_pkg::RUN_PLAYING) begin
                     prod_in = delta_ff * spd;
                     if (loop_mode_ff == ppt_pkg::MODE_RANGE) begin
                        lo_in = pair_lo;
                        hi_in = pair_hi;
                     end else begin
                        lo_in = '0;
                        hi_in = duration_ff;
                     end
                     seq_in = ppt_pkg::SEQ_STEP;
                  end
               end
               ppt_pkg::OP_PLAY: begin
                  run_in = ppt_pkg::RUN_PLAYING;
                  bwd_in = 1'b0;
                  cnt_in = '0;
               end
               ppt_pkg::OP_PAUSE: begin
                  if (run_ff == ppt_pkg::RUN_PLAYING) run_in = ppt_pkg::RUN_PAUSED;
               end
               ppt_pkg::OP_RESUME: begin
                  if (run_ff == ppt_pkg::RUN_PAUSED) run_in = ppt_pkg::RUN_PLAYING;
               end
               ppt_pkg::OP_STOP: begin
                  run_in = ppt_pkg::RUN_STOPPED;
                  cur_in = '0;
                  cnt_in = '0;
                  bwd_in = 1'b0;
               end
               ppt_pkg::OP_SEEK: begin
                  cur_in = clamp_dur($signed({2'b00, target_ff}), duration_ff);
               end
               ppt_pkg::OP_STEP_FWD: begin
                  cur_in = clamp_dur($signed({2'b00, cur_ff})
                                     + $signed((PW+2)'(frame_period_ff)), duration_ff);
               end
               ppt_pkg::OP_STEP_BACK: begin
                  cur_in = clamp_dur($signed({2'b00, cur_ff})
                                     - $signed((PW+2)'(frame_period_ff)), duration_ff);
               end
               ppt_pkg::OP_SCRUB_BEGIN: begin
                  saved_in = run_ff;
                  run_in   = ppt_pkg::RUN_SCRUB;
               end
               ppt_pkg::OP_SCRUB_TO: begin
                  if (run_ff == ppt_pkg::RUN_SCRUB)
                     cur_in = clamp_dur($signed({2'b00, target_ff}), duration_ff);
               end
               ppt_pkg::OP_SCRUB_END: begin
                  if (run_ff == ppt_pkg::RUN_SCRUB) run_in = saved_ff;
               end
               default: begin
               end
            endcase
         end
         ppt_pkg::SEQ_STEP: begin
            len_in = hi_ff - lo_ff;
            np_in  = bwd_ff ? ($signed(NW'(cur_ff)) - $signed(NW'(step)))
                            : ($signed(NW'(cur_ff)) + $signed(NW'(step)));
            seq_in = ppt_pkg::SEQ_EDGE;
         end
         ppt_pkg::SEQ_EDGE: begin
            seq_in = ppt_pkg::SEQ_SEND;
            if (!hit) begin
               cur_in = sat_pos(np_ff);
            end else if (loop_mode_ff == ppt_pkg::MODE_NONE) begin
               run_in   = ppt_pkg::RUN_STOPPED;
               cur_in   = '0;
               cnt_in   = '0;
               bwd_in   = 1'b0;
               ended_in = 1'b1;
            end else if (loop_mode_ff == ppt_pkg::MODE_PING) begin
               cur_in     = sat_pos(refl);
               bwd_in     = !bwd_ff;
               cnt_in     = cnt_ff + 1'b1;
               wrapped_in = 1'b1;
            end else if (len_ff == '0) begin
               cur_in     = lo_ff;
               cnt_in     = cnt_ff + 1'b1;
               wrapped_in = 1'b1;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = bwd_ff ? ppt_pkg::DVD_W'(lo_s - np_ff)
                                         : ppt_pkg::DVD_W'(np_ff - hi_s);
               seq_in = ppt_pkg::SEQ_DIV;
            end
         end
         ppt_pkg::SEQ_DIV: begin
            if (!div_rsp.busy) seq_in = ppt_pkg::SEQ_WRAP;
         end
         ppt_pkg::SEQ_WRAP: begin
            cur_in     = bwd_ff ? (hi_ff - div_rsp.remainder)
                                : (lo_ff + div_rsp.remainder);
            cnt_in     = cnt_ff + 1'b1;
            wrapped_in = 1'b1;
            seq_in     = ppt_pkg::SEQ_SEND;
         end
         ppt_pkg::SEQ_SEND: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_position_in = cur_ff;
               rsp_state_in    = run_ff;
               rsp_reverse_in  = bwd_ff;
               rsp_loops_in    = cnt_ff;
               rsp_wrap_in     = wrapped_ff;
               rsp_end_in      = ended_ff;
               seq_in          = ppt_pkg::SEQ_IDLE;
            end
         end
         default: seq_in = ppt_pkg::SEQ_IDLE;
      endcase

      if (csr_wr_en && (csr_index == ppt_pkg::CSR_DURATION) && (cur_ff > csr_data))
         cur_in = csr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duration_ff     <= '0;
         loop_start_ff   <= '0;
         loop_end_ff     <= '0;
         loop_mode_ff    <= ppt_pkg::MODE_NONE;
         speed_ff        <= ppt_pkg::SPEED_RESET;
         frame_period_ff <= ppt_pkg::FRAME_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            ppt_pkg::CSR_DURATION:     duration_ff     <= csr_data;
            ppt_pkg::CSR_LOOP_START:   loop_start_ff   <= csr_data;
            ppt_pkg::CSR_LOOP_END:     loop_end_ff     <= csr_data;
            ppt_pkg::CSR_LOOP_MODE:    loop_mode_ff    <= csr_data[ppt_pkg::MODE_W-1:0];
            ppt_pkg::CSR_SPEED:        speed_ff        <= csr_data[ppt_pkg::SPEED_W-1:0];
            ppt_pkg::CSR_FRAME_PERIOD: frame_period_ff <= csr_data[ppt_pkg::FRAME_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= ppt_pkg::SEQ_IDLE;
         cur_ff       <= '0;
         run_ff       <= ppt_pkg::RUN_STOPPED;
         saved_ff     <= ppt_pkg::RUN_STOPPED;
         bwd_ff       <= 1'b0;
         cnt_ff       <= '0;
         wrapped_ff   <= 1'b0;
         ended_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         cur_ff       <= cur_in;
         run_ff       <= run_in;
         saved_ff     <= saved_in;
         bwd_ff       <= bwd_in;
         cnt_ff       <= cnt_in;
         wrapped_ff   <= wrapped_in;
         ended_ff     <= ended_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff           <= op_in;
      delta_ff        <= delta_in;
      target_ff       <= target_in;
      prod_ff         <= prod_in;
      lo_ff           <= lo_in;
      hi_ff           <= hi_in;
      len_ff          <= len_in;
      np_ff           <= np_in;
      rsp_position_ff <= rsp_position_in;
      rsp_state_ff    <= rsp_state_in;
      rsp_reverse_ff  <= rsp_reverse_in;
      rsp_loops_ff    <= rsp_loops_in;
      rsp_wrap_ff     <= rsp_wrap_in;
      rsp_end_ff      <= rsp_end_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_position       = rsp_position_ff;
   assign rsp_play_state     = rsp_state_ff;
   assign rsp_reverse        = rsp_reverse_ff;
   assign rsp_loops_done     = rsp_loops_ff;
   assign rsp_loop_completed = rsp_wrap_ff;
   assign rsp_reached_end    = rsp_end_ff;

endmodule

FILE: tb/playback_position_transport_top_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for playback_position_transport_top: directed and random
// transport requests, an in-line status predictor and a field-by-field checker.
// Depends on ppt_pkg and the playback_position_transport_top RTL.

module playback_position_transport_top_tb;
   import ppt_pkg::*;

   localparam int LIMIT_CYCLES  = 400000;
   localparam int SETTLE_CYCLES = 60;
   localparam int REPORT_CAP    = 100;
   localparam int STEP_SHIFT    = DELTA_FRAC_BITS + SPEED_FRAC_BITS - POS_FRAC_BITS;
   localparam logic [OP_W-1:0]  OP_UNUSED_LOW  = 4'd11;
   localparam logic [OP_W-1:0]  OP_UNUSED_HIGH = 4'd15;
   localparam logic [POS_W-1:0] POS_MAX    = '1;
   localparam logic [POS_W-1:0] ONE_SECOND = 32'h0001_0000;

   typedef struct {
      logic [POS_W-1:0]   position;
      logic [STATE_W-1:0] play_state;
      logic               reverse;
      logic [POS_W-1:0]   loops_done;
      logic               loop_completed;
      logic               reached_end;
   } transport_status_t;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [OP_W-1:0]       req_operation = '0;
   logic [DELTA_W-1:0]    req_delta_time = '0;
   logic [POS_W-1:0]      req_target_time = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [POS_W-1:0]      rsp_position;
   logic [STATE_W-1:0]    rsp_play_state;
   logic                  rsp_reverse;
   logic [POS_W-1:0]      rsp_loops_done;
   logic                  rsp_loop_completed;
   logic                  rsp_reached_end;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   logic [POS_W-1:0]   set_duration, set_loop_start, set_loop_end;
   mode_type           set_mode;
   logic [SPEED_W-1:0] set_speed;
   logic [FRAME_W-1:0] set_frame;
   logic [POS_W-1:0]   track_position, track_loops;
   run_type            track_run, track_saved_run;
   logic               track_backward;

   transport_status_t predicted_status[$];
   int fail_count   = 0;
   int cycle_count  = 0;
   int hold_request = 0;
   bit idling_on    = 1'b1;

   playback_position_transport_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_delta_time     (req_delta_time),
      .req_target_time    (req_target_time),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_position       (rsp_position),
      .rsp_play_state     (rsp_play_state),
      .rsp_reverse        (rsp_reverse),
      .rsp_loops_done     (rsp_loops_done),
      .rsp_loop_completed (rsp_loop_completed),
      .rsp_reached_end    (rsp_reached_end),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [POS_W-1:0] clamp_to_timeline(input longint t);
      if (t < 0) return '0;
      if (t > longint'(set_duration)) return set_duration;
      return t[POS_W-1:0];
   endfunction

   function automatic void halt_transport();
      track_run      = RUN_STOPPED;
      track_position = '0;
      track_loops    = '0;
      track_backward = 1'b0;
   endfunction

   function automatic void apply_register(input csr_type index, input logic [CSR_DATA_W-1:0] value);
      case (index)
         CSR_DURATION: begin
            set_duration = value;
            if (track_position > set_duration) track_position = set_duration;
         end
         CSR_LOOP_START:   set_loop_start = value;
         CSR_LOOP_END:     set_loop_end = value;
         CSR_LOOP_MODE:    set_mode = mode_type'(value[MODE_W-1:0]);
         CSR_SPEED:        set_speed = value[SPEED_W-1:0];
         CSR_FRAME_PERIOD: set_frame = value[FRAME_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic transport_status_t advance_transport(input logic [OP_W-1:0] op,
         input logic [DELTA_W-1:0] delta, input logic [POS_W-1:0] target);
      transport_status_t status;
      logic wrapped, ended;
      logic [POS_W-1:0] span_a, span_b;
      longint spd, step, np, lo, hi, len;
      wrapped = 1'b0;
      ended   = 1'b0;
      case (op)
         OP_TICK: if (track_run == RUN_PLAYING) begin
            spd = set_speed;
            if (spd < SPEED_MIN_Q) spd = SPEED_MIN_Q;
            if (spd > SPEED_MAX_Q) spd = SPEED_MAX_Q;
            step = (longint'(delta) * spd) >> STEP_SHIFT;
            if (set_mode == MODE_RANGE) begin
               span_a = (set_loop_start < set_loop_end) ? set_loop_start : set_loop_end;
               span_b = (set_loop_start < set_loop_end) ? set_loop_end : set_loop_start;
               if (span_a > set_duration) span_a = set_duration;
               if (span_b > set_duration) span_b = set_duration;
               lo = span_a;
               hi = span_b;
            end else begin
               lo = 0;
               hi = set_duration;
            end
            len = hi - lo;
            if (!track_backward) begin
               np = longint'(track_position) + step;
               if (np >= hi) begin
                  if (set_mode == MODE_NONE) ended = 1'b1;
                  else if (set_mode == MODE_PING) begin
                     np = hi - (np - hi);
                     if (np < 0) np = 0;
                     track_backward = 1'b1;
                  end else np = (len > 0) ? lo + (np - hi) % len : lo;
                  wrapped = !ended;
               end
            end else begin
               np = longint'(track_position) - step;
               if (np <= lo) begin
                  if (set_mode == MODE_NONE) ended = 1'b1;
                  else if (set_mode == MODE_PING) begin
                     np = lo + (lo - np);
                     track_backward = 1'b0;
                  end else np = (len > 0) ? hi - (lo - np) % len : lo;
                  wrapped = !ended;
               end
            end
            if (ended) halt_transport();
            else begin
               if (np < 0) np = 0;
               if (np > longint'(POS_MAX)) np = longint'(POS_MAX);
               track_position = np[POS_W-1:0];
               if (wrapped) track_loops = track_loops + 1'b1;
            end
         end
         OP_PLAY: begin
            track_run      = RUN_PLAYING;
            track_backward = 1'b0;
            track_loops    = '0;
         end
         OP_PAUSE:  if (track_run == RUN_PLAYING) track_run = RUN_PAUSED;
         OP_RESUME: if (track_run == RUN_PAUSED) track_run = RUN_PLAYING;
         OP_STOP:   halt_transport();
         OP_SEEK:   track_position = clamp_to_timeline(longint'(target));
         OP_STEP_FWD:
            track_position = clamp_to_timeline(longint'(track_position) + longint'(set_frame));
         OP_STEP_BACK:
            track_position = clamp_to_timeline(longint'(track_position) - longint'(set_frame));
         OP_SCRUB_BEGIN: begin
            track_saved_run = track_run;
            track_run       = RUN_SCRUB;
         end
         OP_SCRUB_TO:
            if (track_run == RUN_SCRUB) track_position = clamp_to_timeline(longint'(target));
         OP_SCRUB_END: if (track_run == RUN_SCRUB) track_run = track_saved_run;
         default: ;
      endcase
      status.position       = track_position;
      status.play_state     = track_run;
      status.reverse        = track_backward;
      status.loops_done     = track_loops;
      status.loop_completed = wrapped;
      status.reached_end    = ended;
      return status;
   endfunction

   task automatic report_mismatch(input string what, input logic [POS_W-1:0] got,
         input logic [POS_W-1:0] want);
      fail_count++;
      if (fail_count <= REPORT_CAP)
         $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
   endtask

   task automatic send_request(input logic [OP_W-1:0] op, input logic [DELTA_W-1:0] delta,
         input logic [POS_W-1:0] target);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_delta_time  <= delta;
      req_target_time <= target;
      do @(posedge clock); while (!req_ready);
      predicted_status.push_back(advance_transport(op, delta, target));
   endtask

   task automatic send_random_request();
      logic [OP_W-1:0]    op;
      logic [DELTA_W-1:0] delta;
      logic [POS_W-1:0]   target;
      int roll;
      roll = $urandom_range(0, 99);
      if (track_run != RUN_PLAYING && roll < 30)
         op = (track_run == RUN_PAUSED && roll < 15) ? OP_RESUME : OP_PLAY;
      else if (roll < 62) op = OP_TICK;
      else if (roll < 66) op = OP_PAUSE;
      else if (roll < 69) op = OP_RESUME;
      else if (roll < 72) op = OP_STOP;
      else if (roll < 78) op = OP_SEEK;
      else if (roll < 82) op = OP_STEP_FWD;
      else if (roll < 86) op = OP_STEP_BACK;
      else if (roll < 89) op = OP_SCRUB_BEGIN;
      else if (roll < 94) op = OP_SCRUB_TO;
      else if (roll < 97) op = OP_SCRUB_END;
      else if (roll < 98) op = OP_PLAY;
      else op = $urandom_range(OP_UNUSED_LOW, OP_UNUSED_HIGH);
      case ($urandom_range(0, 7))
         0:       delta = '0;
         1:       delta = '1;
         2, 3:    delta = $urandom_range(0, 16'h0FFF);
         default: delta = $urandom();
      endcase
      case ($urandom_range(0, 7))
         0:       target = '0;
         1:       target = POS_MAX;
         2:       target = set_duration;
         3:       target = set_duration - $urandom_range(0, 16'hFFFF);
         4:       target = $urandom();
         default: target = $urandom_range(0, set_duration);
      endcase
      send_request(op, delta, target);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (predicted_status.size() != 0) @(posedge clock);
   endtask

   task automatic program_transport(input logic [POS_W-1:0] duration,
         input logic [POS_W-1:0] span_a, input logic [POS_W-1:0] span_b,
         input mode_type mode, input logic [SPEED_W-1:0] speed,
         input logic [FRAME_W-1:0] frame);
      logic [CSR_DATA_W-1:0] values [6];
      values = '{duration, span_a, span_b, CSR_DATA_W'(mode), CSR_DATA_W'(speed),
                 CSR_DATA_W'(frame)};
      for (int i = CSR_DURATION; i <= CSR_FRAME_PERIOD; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= csr_type'(i);
         csr_data  <= values[i];
         apply_register(csr_type'(i), values[i]);
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [POS_W-1:0] pick_bound(input logic [POS_W-1:0] duration);
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return duration;
         2:       return $urandom();
         default: return $urandom_range(0, duration);
      endcase
   endfunction

   task automatic test_directed_commands();
      drain_results();
      program_transport(32'h0002_0000, '0, '0, MODE_NONE, SPEED_RESET, FRAME_RESET);
      send_request(OP_TICK, '1, '0);
      send_request(OP_UNUSED_HIGH, '1, POS_MAX);
      send_request(OP_PAUSE, '0, '0);
      send_request(OP_SCRUB_TO, '0, 32'h0000_8000);
      send_request(OP_SCRUB_END, '0, '0);
      send_request(OP_SEEK, '0, POS_MAX);
      send_request(OP_STEP_FWD, '0, '0);
      send_request(OP_PLAY, '0, '0);
      send_request(OP_TICK, '1, '0);
      send_request(OP_STEP_BACK, '0, '0);
      send_request(OP_PLAY, '0, '0);
      send_request(OP_PAUSE, '0, '0);
      send_request(OP_TICK, '1, '0);
      send_request(OP_RESUME, '0, '0);
      send_request(OP_SCRUB_BEGIN, '0, '0);
      send_request(OP_SCRUB_BEGIN, '0, '0);
      send_request(OP_SCRUB_TO, '0, ONE_SECOND);
      send_request(OP_SCRUB_END, '0, '0);
      send_request(OP_STOP, '0, '0);
      drain_results();
   endtask

   task automatic test_loop_boundaries();
      program_transport(ONE_SECOND, '0, ONE_SECOND, MODE_PING, SPEED_RESET, FRAME_RESET);
      send_request(OP_SEEK, '0, 32'h0000_E666);
      send_request(OP_PLAY, '0, '0);
      send_request(OP_TICK, 16'h4000, '0);
      drain_results();
      // reversed bounds; wrap backward inside the range
      program_transport(ONE_SECOND, 32'h0000_C000, 32'h0000_4000, MODE_RANGE, SPEED_RESET,
                        FRAME_RESET);
      send_request(OP_TICK, 16'h8000, '0);
      send_request(OP_TICK, 16'h8000, '0);
      drain_results();
      // reflect below zero at full speed
      program_transport(ONE_SECOND, '0, '0, MODE_PING, SPEED_W'(SPEED_MAX_Q), FRAME_RESET);
      send_request(OP_PLAY, '0, '0);
      send_request(OP_TICK, '1, '0);
      drain_results();
      // zero-length loop
      program_transport('0, '0, '0, MODE_WHOLE, SPEED_RESET, FRAME_RESET);
      send_request(OP_PLAY, '0, '0);
      send_request(OP_TICK, '0, '0);
      drain_results();
   endtask

   task automatic test_random_settings();
      logic [POS_W-1:0]   duration, span_a, span_b;
      logic [SPEED_W-1:0] speed;
      logic [FRAME_W-1:0] frame;
      for (int phase = 0; phase < 12; phase++) begin
         case (phase)
            0: begin
               duration = POS_MAX;
               span_a   = POS_MAX;
               span_b   = '0;
               speed    = '1;
               frame    = '1;
            end
            1: begin
               duration = '0;
               span_a   = '0;
               span_b   = POS_MAX;
               speed    = '0;
               frame    = '0;
            end
            default: begin
               case ($urandom_range(0, 5))
                  0:       duration = $urandom_range(0, ONE_SECOND);
                  4:       duration = $urandom();
                  5:       duration = POS_MAX - $urandom_range(0, 32 * ONE_SECOND);
                  default: duration = $urandom_range(ONE_SECOND, 32 * ONE_SECOND);
               endcase
               span_a = pick_bound(duration);
               span_b = ($urandom_range(0, 7) == 0) ? span_a : pick_bound(duration);
               case ($urandom_range(0, 3))
                  0:       speed = SPEED_RESET;
                  1:       speed = $urandom_range(0, (1 << SPEED_W) - 1);
                  default: speed = $urandom_range(SPEED_MIN_Q, SPEED_MAX_Q);
               endcase
               frame = ($urandom_range(0, 3) == 0) ? FRAME_W'($urandom())
                                                   : FRAME_W'($urandom_range(1, 1 << 16));
            end
         endcase
         program_transport(duration, span_a, span_b, mode_type'((phase + 2) % 4), speed,
                           frame);
         repeat (55) send_random_request();
         drain_results();
      end
   endtask

   task automatic test_output_backpressure();
      idling_on    = 1'b0;
      hold_request = 300;
      repeat (12) send_random_request();
      drain_results();
   endtask

   task automatic test_back_to_back();
      idling_on = 1'b0;
      program_transport(8 * ONE_SECOND, ONE_SECOND, 3 * ONE_SECOND, MODE_WHOLE,
                        SPEED_W'(SPEED_MAX_Q), FRAME_RESET);
      repeat (70) send_random_request();
      drain_results();
   endtask

   initial begin : receiver
      int hold_left;
      int stall_left;
      hold_left  = 0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 8);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      transport_status_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_status.size() == 0) begin
            report_mismatch("unexpected result, position", rsp_position, '0);
         end else begin
            want = predicted_status.pop_front();
            if (rsp_position !== want.position)
               report_mismatch("position", rsp_position, want.position);
            if (rsp_play_state !== want.play_state)
               report_mismatch("play_state", rsp_play_state, want.play_state);
            if (rsp_reverse !== want.reverse)
               report_mismatch("reverse", rsp_reverse, want.reverse);
            if (rsp_loops_done !== want.loops_done)
               report_mismatch("loops_done", rsp_loops_done, want.loops_done);
            if (rsp_loop_completed !== want.loop_completed)
               report_mismatch("loop_completed", rsp_loop_completed, want.loop_completed);
            if (rsp_reached_end !== want.reached_end)
               report_mismatch("reached_end", rsp_reached_end, want.reached_end);
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("playback_position_transport_top verification failed");
      $finish;
   end

   initial begin
      set_duration    = '0;
      set_loop_start  = '0;
      set_loop_end    = '0;
      set_mode        = MODE_NONE;
      set_speed       = SPEED_RESET;
      set_frame       = FRAME_RESET;
      track_saved_run = RUN_STOPPED;
      halt_transport();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_commands();
      test_loop_boundaries();
      test_random_settings();
      test_output_backpressure();
      test_back_to_back();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("playback_position_transport_top verification clean");
      else
         $display("playback_position_transport_top verification failed");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/ppt_pkg.sv
rtl/ppt_urem.sv
rtl/playback_position_transport_top.sv
tb/playback_position_transport_top_tb.sv
